FILE: rtl/jmsp_pkg.sv
package jmsp_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_word;

    // Byte and marker codes
    localparam t_byte BYTE_FF   = 8'hFF;
    localparam t_byte CODE_SOI  = 8'hD8;
    localparam t_byte CODE_EOI  = 8'hD9;
    localparam t_byte CODE_SOS  = 8'hDA;
    localparam t_byte CODE_APP0 = 8'hE0;
    localparam t_byte CODE_DHT  = 8'hC4;
    localparam t_byte CODE_JPG  = 8'hC8;
    localparam t_byte CODE_DAC  = 8'hCC;

    // Defaults and segment length limits
    localparam t_word DEFAULT_DENSITY   = 16'd300;
    localparam t_byte DEFAULT_UNITS     = 8'd1;
    localparam t_byte DEFAULT_PAD_LIMIT = 8'd10;
    localparam t_word MIN_JFIF_LEN      = 16'd16;
    localparam t_word MIN_SOF_LEN       = 16'd8;
    localparam t_word MIN_SEG_LEN       = 16'd2;

    // Byte offsets inside a segment, counted from the first length byte
    localparam t_word OFS_SOF_HEIGHT_HI = 16'd3;
    localparam t_word OFS_SOF_HEIGHT_LO = 16'd4;
    localparam t_word OFS_SOF_WIDTH_HI  = 16'd5;
    localparam t_word OFS_SOF_WIDTH_LO  = 16'd6;
    localparam t_word OFS_SOF_NCOMP     = 16'd7;
    localparam t_word OFS_JFIF_UNITS    = 16'd9;
    localparam t_word OFS_JFIF_XDENS_HI = 16'd10;
    localparam t_word OFS_JFIF_XDENS_LO = 16'd11;
    localparam t_word OFS_JFIF_YDENS_HI = 16'd12;
    localparam t_word OFS_JFIF_YDENS_LO = 16'd13;
    localparam t_byte COLOR_NCOMP       = 8'd3;

    typedef enum logic [2:0] {
        PH_SOI0,
        PH_SOI1,
        PH_SEARCH,
        PH_LENHI,
        PH_LENLO,
        PH_BODY,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        EV_SEG     = 3'd0,
        EV_SOS     = 3'd1,
        EV_NOIMG   = 3'd2,
        EV_NOTJPEG = 3'd3,
        EV_TRUNC   = 3'd4,
        EV_BADLEN  = 3'd5
    } t_event;

    // Staging values captured in a segment body, committed when it completes
    typedef struct packed {
        t_word a;
        t_word b;
        t_byte c;
    } t_stage;

    localparam t_stage STAGE_CLEAR = '{a: 16'd0, b: 16'd0, c: 8'd0};

    typedef struct packed {
        t_phase phase;
        logic   prev_ff;
        t_byte  pad_cnt;
        t_byte  marker;
        t_word  seg_len;
        t_word  seg_off;
        t_word  height;
        t_word  width;
        logic   color;
        t_byte  process;
        t_byte  units;
        t_word  xdens;
        t_word  ydens;
        logic   jfif;
        t_stage stage;
        logic   warn;
    } t_state;

    localparam t_state ST_RESET = '{
        phase:   PH_SOI0,
        prev_ff: 1'b0,
        pad_cnt: 8'd0,
        marker:  8'd0,
        seg_len: 16'd0,
        seg_off: 16'd0,
        height:  16'd0,
        width:   16'd0,
        color:   1'b0,
        process: 8'd0,
        units:   DEFAULT_UNITS,
        xdens:   DEFAULT_DENSITY,
        ydens:   DEFAULT_DENSITY,
        jfif:    1'b0,
        stage:   STAGE_CLEAR,
        warn:    1'b0
    };

    typedef struct packed {
        t_event event_res;
        t_byte  marker;
        t_word  section_length;
        logic   pad_warning;
        t_word  image_height;
        t_word  image_width;
        logic   is_color;
        t_byte  sof_process;
        t_byte  density_units;
        t_word  x_density;
        t_word  y_density;
        logic   jfif_present;
    } t_result;

    // Start-of-frame markers: C0 to CF except DHT, JPG and DAC
    function automatic logic is_sof(input t_byte m);
        logic hit;
        hit = (m[7:4] == 4'hC) && (m != CODE_DHT) && (m != CODE_JPG) && (m != CODE_DAC);
        return hit;
    endfunction

endpackage

FILE: rtl/jmsp_ifs.sv
// Byte stream channel
interface jmsp_byte_if import jmsp_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte data_byte;
    logic  file_start;
    logic  file_end;

    modport source (output valid, data_byte, file_start, file_end, input ready);
    modport sink (input valid, data_byte, file_start, file_end, output ready);
endinterface

// Segment result channel
interface jmsp_result_if import jmsp_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    t_byte      marker;
    t_word      section_length;
    logic       pad_warning;
    t_word      image_height;
    t_word      image_width;
    logic       is_color;
    t_byte      sof_process;
    t_byte      density_units;
    t_word      x_density;
    t_word      y_density;
    logic       jfif_present;

    modport source (output valid, event_res, marker, section_length, pad_warning,
                    image_height, image_width, is_color, sof_process, density_units,
                    x_density, y_density, jfif_present, input ready);
    modport sink (input valid, event_res, marker, section_length, pad_warning,
                  image_height, image_width, is_color, sof_process, density_units,
                  x_density, y_density, jfif_present, output ready);
endinterface

FILE: rtl/jpeg_marker_segment_parser_core.sv
// Channel   Direction  Handshake      Payload
// i_byte    in         valid/ready    data_byte, file_start, file_end
// o_res     out        valid/ready    event_res, marker, section_length, pad_warning,
//                                     image fields, density fields, jfif_present
// i_cfg_*   in         write enable   pad warning limit (8 bits)
//
// One byte per cycle sustained while the result is not stalled. A byte is parsed straight
// out of the input register, and its result is held in the result register, from which
// it can be taken.
// A byte is parsed only when the result register is empty or being read, so a stalled
// result holds the parser and, one byte later, the input.
// Reset is synchronous on i_rst_n low and returns the parser and the limit to defaults.
module jpeg_marker_segment_parser_core import jmsp_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    jmsp_byte_if.sink     i_byte,
    jmsp_result_if.source o_res,
    input  logic          i_cfg_we,
    input  t_byte         i_cfg_wdata
);

    // Input register
    logic   r_in_vld;
    t_byte  r_in_data;
    logic   r_in_start;
    logic   r_in_end;

    // Parser state, limit and result register
    t_state  r_st;
    t_state  n_st;
    t_state  s_st;
    t_byte   r_pad_limit;
    t_result r_res;
    t_result n_res;
    logic    r_out_vld;

    logic   w_adv;
    logic   w_accept;
    t_stage w_cap;

    // Decisions of the phase logic
    t_phase w_phase;
    logic   w_ev_vld;
    t_event w_ev;
    logic   w_seg;
    logic   w_end_srch;
    logic   w_is_mark;
    t_word  w_len_lo;
    t_word  w_off_inc;
    t_phase w_pre_end;
    logic   w_fin;

    // Handshake: parse when the result slot is free or being emptied
    assign w_adv        = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_byte.ready = !r_in_vld || w_adv;
    assign w_accept     = i_byte.valid && i_byte.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_accept) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_data  <= i_byte.data_byte;
            r_in_start <= i_byte.file_start;
            r_in_end   <= i_byte.file_end;
        end
    end

    // A file start restarts the parser on this very byte
    assign s_st = r_in_start ? ST_RESET : r_st;

    assign w_is_mark = s_st.prev_ff && (r_in_data != BYTE_FF);
    assign w_len_lo  = {s_st.seg_len[15:8], r_in_data};
    assign w_off_inc = s_st.seg_off + 16'd1;

    jmsp_capture u_capture (
        .i_marker  (s_st.marker),
        .i_seg_len (s_st.seg_len),
        .i_seg_off (s_st.seg_off),
        .i_data    (r_in_data),
        .i_stage   (s_st.stage),
        .o_stage   (w_cap)
    );

    // Next phase and event
    always_comb begin
        w_pre_end = s_st.phase;
        w_ev_vld  = 1'b0;
        w_ev      = EV_SEG;
        w_fin     = 1'b0;
        case (s_st.phase)
            PH_SOI0: begin
                if (r_in_data == BYTE_FF) begin
                    w_pre_end = PH_SOI1;
                end else begin
                    w_pre_end = PH_DONE;
                    w_ev_vld  = 1'b1;
                    w_ev      = EV_NOTJPEG;
                end
            end
            PH_SOI1: begin
                if (r_in_data == CODE_SOI) begin
                    w_pre_end = PH_SEARCH;
                end else begin
                    w_pre_end = PH_DONE;
                    w_ev_vld  = 1'b1;
                    w_ev      = EV_NOTJPEG;
                end
            end
            PH_SEARCH: begin
                if (w_is_mark) begin
                    if (r_in_data == CODE_EOI) begin
                        w_pre_end = PH_DONE;
                        w_ev_vld  = 1'b1;
                        w_ev      = EV_NOIMG;
                    end else begin
                        w_pre_end = PH_LENHI;
                    end
                end
            end
            PH_LENHI: begin
                w_pre_end = PH_LENLO;
            end
            PH_LENLO: begin
                if (w_len_lo < MIN_SEG_LEN) begin
                    w_pre_end = PH_DONE;
                    w_ev_vld  = 1'b1;
                    w_ev      = EV_BADLEN;
                end else if (w_len_lo == MIN_SEG_LEN) begin
                    w_fin = 1'b1;
                end else begin
                    w_pre_end = PH_BODY;
                end
            end
            PH_BODY: begin
                w_fin = (w_off_inc == s_st.seg_len);
            end
            default: begin
                w_pre_end = PH_DONE;
            end
        endcase

        // End of a segment: SOS stops with success, anything else goes on searching
        w_seg = 1'b0;
        if (w_fin) begin
            w_ev_vld = 1'b1;
            if (s_st.marker == CODE_SOS) begin
                w_pre_end = PH_DONE;
                w_ev      = EV_SOS;
            end else begin
                w_pre_end = PH_SEARCH;
                w_ev      = EV_SEG;
                w_seg     = 1'b1;
            end
        end

        // End of the file while still running
        w_phase    = w_pre_end;
        w_end_srch = 1'b0;
        if (w_seg) begin
            if (r_in_end) begin
                w_ev    = EV_TRUNC;
                w_phase = PH_DONE;
            end
        end else if (r_in_end && (w_pre_end != PH_DONE)) begin
            w_ev_vld   = 1'b1;
            w_ev       = ((w_pre_end == PH_SOI0) || (w_pre_end == PH_SOI1)) ?
                         EV_NOTJPEG : EV_TRUNC;
            w_end_srch = (w_pre_end == PH_SEARCH);
            w_phase    = PH_DONE;
        end
    end

    // Data registers and result fields
    always_comb begin
        n_st       = s_st;
        n_st.phase = w_phase;
        case (s_st.phase)
            PH_SOI1: begin
                n_st.prev_ff = 1'b0;
                n_st.pad_cnt = 8'd0;
                n_st.warn    = 1'b0;
            end
            PH_SEARCH: begin
                if (w_is_mark) begin
                    n_st.marker  = r_in_data;
                    n_st.seg_len = 16'd0;
                    n_st.warn    = (s_st.pad_cnt > r_pad_limit);
                end else begin
                    if (s_st.pad_cnt != 8'hFF) begin
                        n_st.pad_cnt = s_st.pad_cnt + 8'd1;
                    end
                    n_st.prev_ff = (r_in_data == BYTE_FF);
                end
            end
            PH_LENHI: begin
                n_st.seg_len = {r_in_data, 8'h00};
            end
            PH_LENLO: begin
                n_st.seg_len = w_len_lo;
                if (w_len_lo >= MIN_SEG_LEN) begin
                    n_st.seg_off = MIN_SEG_LEN;
                    n_st.stage   = STAGE_CLEAR;
                end
            end
            PH_BODY: begin
                n_st.stage   = w_cap;
                n_st.seg_off = w_off_inc;
            end
            default: begin
            end
        endcase

        // Commit captured fields of a finished segment
        if (w_seg) begin
            if (is_sof(n_st.marker) && (n_st.seg_len >= MIN_SOF_LEN)) begin
                n_st.height  = n_st.stage.a;
                n_st.width   = n_st.stage.b;
                n_st.color   = n_st.stage.c[0];
                n_st.process = n_st.marker;
            end else if ((n_st.marker == CODE_APP0) && (n_st.seg_len >= MIN_JFIF_LEN)) begin
                n_st.units = n_st.stage.c;
                n_st.xdens = n_st.stage.a;
                n_st.ydens = n_st.stage.b;
                n_st.jfif  = 1'b1;
            end
            n_st.prev_ff = 1'b0;
            n_st.pad_cnt = 8'd0;
        end

        if (w_end_srch) begin
            n_st.warn = 1'b0;
        end

        n_res.event_res      = w_ev;
        n_res.marker         = n_st.marker;
        n_res.section_length = n_st.seg_len;
        n_res.pad_warning    = n_st.warn;
        n_res.image_height   = n_st.height;
        n_res.image_width    = n_st.width;
        n_res.is_color       = n_st.color;
        n_res.sof_process    = n_st.process;
        n_res.density_units  = n_st.units;
        n_res.x_density      = n_st.xdens;
        n_res.y_density      = n_st.ydens;
        n_res.jfif_present   = n_st.jfif;

        // The warning belongs to the reported segment only
        if (w_seg) begin
            n_st.warn = 1'b0;
        end
    end

    // Parser state and limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_RESET;
            r_pad_limit <= DEFAULT_PAD_LIMIT;
        end else begin
            if (w_adv) begin
                r_st <= n_st;
            end
            if (i_cfg_we) begin
                r_pad_limit <= i_cfg_wdata;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= w_ev_vld;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_ev_vld) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid          = r_out_vld;
    assign o_res.event_res      = r_res.event_res;
    assign o_res.marker         = r_res.marker;
    assign o_res.section_length = r_res.section_length;
    assign o_res.pad_warning    = r_res.pad_warning;
    assign o_res.image_height   = r_res.image_height;
    assign o_res.image_width    = r_res.image_width;
    assign o_res.is_color       = r_res.is_color;
    assign o_res.sof_process    = r_res.sof_process;
    assign o_res.density_units  = r_res.density_units;
    assign o_res.x_density      = r_res.x_density;
    assign o_res.y_density      = r_res.y_density;
    assign o_res.jfif_present   = r_res.jfif_present;

`ifndef SYNTHESIS
    // A stalled result freezes the parser.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_res.ready) |=> $stable(r_st))
        else $error("parser state moved while the result was stalled");

    // Every result other than a plain segment end stops the parser.
    a_stop_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_ev_vld && (w_ev != EV_SEG)) |=> (r_st.phase == PH_DONE))
        else $error("parser kept running after a final result");

    // Inside a segment body the offset stays below the length.
    a_body_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.phase == PH_BODY) |-> (r_st.seg_off < r_st.seg_len))
        else $error("segment offset reached the length inside the body");
`endif

endmodule

FILE: rtl/jmsp_capture.sv
// Field capture for SOFn and JFIF segment bodies. Picks the byte at a known
// offset into the staging registers; everything else passes through.
module jmsp_capture import jmsp_pkg::*; (
    input  t_byte  i_marker,
    input  t_word  i_seg_len,
    input  t_word  i_seg_off,
    input  t_byte  i_data,
    input  t_stage i_stage,
    output t_stage o_stage
);

    logic w_sof;
    logic w_jfif;

    assign w_sof  = is_sof(i_marker) && (i_seg_len >= MIN_SOF_LEN);
    assign w_jfif = (i_marker == CODE_APP0) && (i_seg_len >= MIN_JFIF_LEN);

    // Select the staging field written by this offset
    always_comb begin
        o_stage = i_stage;
        if (w_sof) begin
            if (i_seg_off == OFS_SOF_HEIGHT_HI) begin
                o_stage.a = {i_data, 8'h00};
            end else if (i_seg_off == OFS_SOF_HEIGHT_LO) begin
                o_stage.a = {i_stage.a[15:8], i_data};
            end else if (i_seg_off == OFS_SOF_WIDTH_HI) begin
                o_stage.b = {i_data, 8'h00};
            end else if (i_seg_off == OFS_SOF_WIDTH_LO) begin
                o_stage.b = {i_stage.b[15:8], i_data};
            end else if (i_seg_off == OFS_SOF_NCOMP) begin
                o_stage.c = {7'd0, (i_data == COLOR_NCOMP)};
            end
        end else if (w_jfif) begin
            if (i_seg_off == OFS_JFIF_UNITS) begin
                o_stage.c = i_data;
            end else if (i_seg_off == OFS_JFIF_XDENS_HI) begin
                o_stage.a = {i_data, 8'h00};
            end else if (i_seg_off == OFS_JFIF_XDENS_LO) begin
                o_stage.a = {i_stage.a[15:8], i_data};
            end else if (i_seg_off == OFS_JFIF_YDENS_HI) begin
                o_stage.b = {i_data, 8'h00};
            end else if (i_seg_off == OFS_JFIF_YDENS_LO) begin
                o_stage.b = {i_stage.b[15:8], i_data};
            end
        end
    end

endmodule
